>>> sv/szd_pkg.sv
package szd_pkg;

	// Result kinds
	localparam logic [2:0] KIND_NAME   = 3'd0;
	localparam logic [2:0] KIND_DATA   = 3'd1;
	localparam logic [2:0] KIND_EMPTY  = 3'd2;
	localparam logic [2:0] KIND_END    = 3'd3;
	localparam logic [2:0] KIND_REJECT = 3'd4;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
	} item_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [2:0] kind;
		logic       last;
	} result_t;

	// Local file header signature, byte by byte.
	function automatic logic [7:0] sig_byte(input logic [1:0] idx);
		logic [7:0] v;
		case (idx)
			2'd0: v = 8'h50;
			2'd1: v = 8'h4B;
			2'd2: v = 8'h03;
			2'd3: v = 8'h04;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

>>> sv/szd_in_stage.sv
module szd_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    in_byte,
	input  logic          first_byte,
	input  logic          advance,
	output logic          valid_s1,
	output szd_pkg::item_t item_s1
);
	import szd_pkg::*;

	logic  valid_q;
	item_t item_q;

	// The held word moves on whenever the result register can take its outcome.
	assign in_stall = valid_q && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q.data  <= in_byte;
			item_q.first <= first_byte;
		end
	end

	assign valid_s1 = valid_q;
	assign item_s1  = item_q;

endmodule

>>> sv/szd_parse.sv
module szd_parse (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  logic            advance,
	input  szd_pkg::item_t  item_s1,
	output szd_pkg::result_t res
);
	import szd_pkg::*;

	localparam logic [2:0] PH_HEAD  = 3'd0;
	localparam logic [2:0] PH_NAME  = 3'd1;
	localparam logic [2:0] PH_EXTRA = 3'd2;
	localparam logic [2:0] PH_DATA  = 3'd3;
	localparam logic [2:0] PH_STOP  = 3'd4;

	localparam logic [4:0] HDR_SIG_END   = 5'd4;
	localparam logic [4:0] HDR_PACKED_LO = 5'd18;
	localparam logic [4:0] HDR_PACKED_HI = 5'd21;
	localparam logic [4:0] HDR_PLAIN_LO  = 5'd22;
	localparam logic [4:0] HDR_PLAIN_HI  = 5'd25;
	localparam logic [4:0] HDR_NAME_LO   = 5'd26;
	localparam logic [4:0] HDR_NAME_HI   = 5'd27;
	localparam logic [4:0] HDR_EXTRA_LO  = 5'd28;
	localparam logic [4:0] HDR_LAST      = 5'd29;

	logic [2:0]  phase_q,  phase_nxt;
	logic [4:0]  hcount_q, hcount_nxt;
	logic [31:0] packed_q, packed_nxt;
	logic [31:0] plain_q,  plain_nxt;
	logic [15:0] namelen_q, namelen_nxt;
	logic [15:0] extlen_q, extlen_nxt;
	logic [31:0] remain_q, remain_nxt;

	logic [2:0]  ph;
	logic [4:0]  hc;
	logic [7:0]  b;
	logic [7:0]  lc;
	logic [31:0] rem_dec;
	logic [15:0] ext_shift;
	logic        fire;

	assign fire = valid_s1 && advance;

	always_comb begin
		b         = item_s1.data;
		ph        = item_s1.first ? PH_HEAD : phase_q;
		hc        = item_s1.first ? 5'd0 : hcount_q;
		lc        = (b >= 8'h41 && b <= 8'h5A) ? (b + 8'h20) : b;
		rem_dec   = (remain_q != 32'd0) ? (remain_q - 32'd1) : remain_q;
		ext_shift = {b, extlen_q[15:8]};

		phase_nxt   = ph;
		hcount_nxt  = hc;
		packed_nxt  = packed_q;
		plain_nxt   = plain_q;
		namelen_nxt = namelen_q;
		extlen_nxt  = extlen_q;
		remain_nxt  = remain_q;
		res         = '0;

		case (ph)
			PH_HEAD: begin
				if (hc < HDR_SIG_END && b != sig_byte(hc[1:0])) begin
					phase_nxt = PH_STOP;
					res.valid = 1'b1;
					res.kind  = KIND_END;
				end else begin
					if (hc >= HDR_PACKED_LO && hc <= HDR_PACKED_HI)
						packed_nxt = {b, packed_q[31:8]};
					else if (hc >= HDR_PLAIN_LO && hc <= HDR_PLAIN_HI)
						plain_nxt = {b, plain_q[31:8]};
					else if (hc >= HDR_NAME_LO && hc <= HDR_NAME_HI)
						namelen_nxt = {b, namelen_q[15:8]};
					else if (hc >= HDR_EXTRA_LO)
						extlen_nxt = ext_shift;

					if (hc >= HDR_LAST) begin
						if (packed_q != plain_q) begin
							phase_nxt = PH_STOP;
							res.valid = 1'b1;
							res.kind  = KIND_REJECT;
						end else if (namelen_q != 16'd0) begin
							phase_nxt  = PH_NAME;
							remain_nxt = {16'd0, namelen_q};
						end else if (ext_shift != 16'd0) begin
							phase_nxt  = PH_EXTRA;
							remain_nxt = {16'd0, ext_shift};
						end else if (packed_q != 32'd0) begin
							phase_nxt  = PH_DATA;
							remain_nxt = packed_q;
						end else begin
							phase_nxt  = PH_HEAD;
							hcount_nxt = 5'd0;
							res.valid  = 1'b1;
							res.kind   = KIND_EMPTY;
							res.last   = 1'b1;
						end
					end else begin
						hcount_nxt = hc + 5'd1;
					end
				end
			end
			PH_NAME: begin
				remain_nxt = rem_dec;
				res.valid  = 1'b1;
				res.data   = lc;
				res.kind   = KIND_NAME;
				if (rem_dec == 32'd0) begin
					if (extlen_q != 16'd0) begin
						phase_nxt  = PH_EXTRA;
						remain_nxt = {16'd0, extlen_q};
					end else if (packed_q != 32'd0) begin
						phase_nxt  = PH_DATA;
						remain_nxt = packed_q;
					end else begin
						phase_nxt  = PH_HEAD;
						hcount_nxt = 5'd0;
						res.last   = 1'b1;
					end
				end
			end
			PH_EXTRA: begin
				remain_nxt = rem_dec;
				if (rem_dec == 32'd0) begin
					if (packed_q != 32'd0) begin
						phase_nxt  = PH_DATA;
						remain_nxt = packed_q;
					end else begin
						phase_nxt  = PH_HEAD;
						hcount_nxt = 5'd0;
						res.valid  = 1'b1;
						res.kind   = KIND_EMPTY;
						res.last   = 1'b1;
					end
				end
			end
			PH_DATA: begin
				remain_nxt = rem_dec;
				res.valid  = 1'b1;
				res.data   = b;
				res.kind   = KIND_DATA;
				if (rem_dec == 32'd0) begin
					phase_nxt  = PH_HEAD;
					hcount_nxt = 5'd0;
					res.last   = 1'b1;
				end
			end
			default: begin
				// Stopped: words are dropped until a new archive starts.
			end
		endcase

		res.valid = res.valid && valid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEAD;
			hcount_q  <= 5'd0;
			packed_q  <= 32'd0;
			plain_q   <= 32'd0;
			namelen_q <= 16'd0;
			extlen_q  <= 16'd0;
			remain_q  <= 32'd0;
		end else if (fire) begin
			phase_q   <= phase_nxt;
			hcount_q  <= hcount_nxt;
			packed_q  <= packed_nxt;
			plain_q   <= plain_nxt;
			namelen_q <= namelen_nxt;
			extlen_q  <= extlen_nxt;
			remain_q  <= remain_nxt;
		end
	end

endmodule

>>> sv/szd_out_stage.sv
module szd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  szd_pkg::result_t res,
	output logic             advance,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic [2:0]       kind,
	output logic             last_of_entry
);
	import szd_pkg::*;

	logic       valid_q;
	logic [7:0] data_q;
	logic [2:0] kind_q;
	logic       last_q;

	// The register can be loaded when it is empty or its word leaves this cycle.
	assign advance = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			data_q <= res.data;
			kind_q <= res.kind;
			last_q <= res.last;
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = data_q;
	assign kind          = kind_q;
	assign last_of_entry = last_q;

endmodule

>>> sv/stored_zip_entry_deframer.sv
// A word taken into the input register gives its result, if any, on the outputs
// from the result register, once that register can be loaded.
// Throughput: one byte per cycle; the input stalls only while the result register
// holds a word under out_stall and the input register is also full.
// Reset: arst_n clears the parse state and both valid flags at once.
module stored_zip_entry_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       first_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [2:0] kind,
	output logic       last_of_entry
);
	import szd_pkg::*;

	logic    advance;
	logic    valid_s1;
	item_t   item_s1;
	result_t res;

	szd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.first_byte (first_byte),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	szd_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.advance  (advance),
		.item_s1  (item_s1),
		.res      (res)
	);

	szd_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res           (res),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.kind          (kind),
		.last_of_entry (last_of_entry)
	);

endmodule

>>> sv/szd_checker.sv
module szd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic [2:0] kind,
	input logic       last_of_entry
);
	import szd_pkg::*;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(kind)
			&& $stable(last_of_entry))
		else $error("result word changed while stalled");

	// With the output side free, the input side never stalls.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output free");

	// Archive end and rejection carry no byte and do not end an entry.
	a_stop_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_END || kind == KIND_REJECT)
			|-> out_byte == 8'h00 && !last_of_entry)
		else $error("stop result with payload");

	// An empty-content marker always closes its entry.
	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_EMPTY |-> last_of_entry && out_byte == 8'h00)
		else $error("empty entry marker malformed");

	// Name bytes never come out as upper-case letters.
	a_lower: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_NAME |-> out_byte < 8'h41 || out_byte > 8'h5A)
		else $error("name byte not lowercased");

endmodule

bind stored_zip_entry_deframer szd_checker u_szd_checker (.*);

>>> tb/stored_zip_entry_deframer_tb.sv
`timescale 1ns / 100ps

module stored_zip_entry_deframer_tb;
	import szd_pkg::*;

	localparam logic [31:0] ZIP_SIG = 32'h04034B50;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int RANDOM_WORDS = 400;

	typedef enum logic [2:0] {
		ST_HEADER,
		ST_NAME,
		ST_EXTRA,
		ST_DATA,
		ST_STOPPED
	} parse_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] kind;
		logic       last;
	} deframed_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       typed;
		logic       t_has;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       first_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic [2:0] kind;
	logic       last_of_entry;

	// Parser state as the block should hold it.
	parse_state_t p_state;
	logic [4:0]   p_hdr_idx;
	logic [31:0]  p_packed;
	logic [31:0]  p_plain;
	logic [31:0]  p_left;
	logic [15:0]  p_name_len;
	logic [15:0]  p_extra_len;

	deframed_t pending_words[$];
	stim_row_t dir_rows[$];

	int error_count = 0;
	int words_fed = 0;
	int words_total = 0;
	int entries_sent = 0;
	int kind_count[8];
	int idle_pct = 0;
	bit hold_long = 1'b0;
	bit quiet_tail = 1'b0;

	stored_zip_entry_deframer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.first_byte   (first_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.kind         (kind),
		.last_of_entry(last_of_entry)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("%0t ERROR %s", $time, msg);
	endtask

	task automatic queue_word(input deframed_t w);
		pending_words.insert(pending_words.size(), w);
	endtask

	task automatic add_row(input logic [7:0] d, input logic f, input logic ty,
			input logic th);
		stim_row_t row;
		row.data = d;
		row.first = f;
		row.typed = ty;
		row.t_has = th;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	// Steps to the next non-empty section after the one given. Returns 1 when
	// the entry has nothing left, so the parser is back at a header.
	function automatic bit enter_next_section(input parse_state_t from);
		if (from == ST_HEADER && p_name_len != 16'd0) begin
			p_state = ST_NAME;
			p_left = {16'd0, p_name_len};
			return 1'b0;
		end
		if (from != ST_EXTRA && p_extra_len != 16'd0) begin
			p_state = ST_EXTRA;
			p_left = {16'd0, p_extra_len};
			return 1'b0;
		end
		if (p_packed != 32'd0) begin
			p_state = ST_DATA;
			p_left = p_packed;
			return 1'b0;
		end
		p_state = ST_HEADER;
		p_hdr_idx = 5'd0;
		return 1'b1;
	endfunction

	task automatic deframe_byte(input logic [7:0] b, input logic f, output bit has,
			output deframed_t w);
		has = 1'b0;
		w = '0;
		if (f) begin
			p_state = ST_HEADER;
			p_hdr_idx = 5'd0;
		end
		case (p_state)
			ST_HEADER: begin
				if (p_hdr_idx < 5'd4 && b != ZIP_SIG[8 * p_hdr_idx[1:0] +: 8]) begin
					p_state = ST_STOPPED;
					has = 1'b1;
					w = {8'h00, KIND_END, 1'b0};
				end else begin
					if (p_hdr_idx >= 5'd18 && p_hdr_idx <= 5'd21)
						p_packed = {b, p_packed[31:8]};
					else if (p_hdr_idx >= 5'd22 && p_hdr_idx <= 5'd25)
						p_plain = {b, p_plain[31:8]};
					else if (p_hdr_idx >= 5'd26 && p_hdr_idx <= 5'd27)
						p_name_len = {b, p_name_len[15:8]};
					else if (p_hdr_idx >= 5'd28)
						p_extra_len = {b, p_extra_len[15:8]};
					if (p_hdr_idx == 5'd29) begin
						if (p_packed != p_plain) begin
							p_state = ST_STOPPED;
							has = 1'b1;
							w = {8'h00, KIND_REJECT, 1'b0};
						end else if (enter_next_section(ST_HEADER)) begin
							has = 1'b1;
							w = {8'h00, KIND_EMPTY, 1'b1};
						end
					end else begin
						p_hdr_idx = p_hdr_idx + 5'd1;
					end
				end
			end
			ST_NAME: begin
				has = 1'b1;
				w.data = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
				w.kind = KIND_NAME;
				if (p_left != 32'd0)
					p_left = p_left - 32'd1;
				w.last = (p_left == 32'd0) ? enter_next_section(ST_NAME) : 1'b0;
			end
			ST_EXTRA: begin
				if (p_left != 32'd0)
					p_left = p_left - 32'd1;
				if (p_left == 32'd0 && enter_next_section(ST_EXTRA)) begin
					has = 1'b1;
					w = {8'h00, KIND_EMPTY, 1'b1};
				end
			end
			ST_DATA: begin
				if (p_left != 32'd0)
					p_left = p_left - 32'd1;
				has = 1'b1;
				w = {b, KIND_DATA, p_left == 32'd0};
				if (p_left == 32'd0) begin
					p_state = ST_HEADER;
					p_hdr_idx = 5'd0;
				end
			end
			default: ;
		endcase
	endtask

	// Offers one word, waits for it to be taken, then records what it should
	// produce. A typed row overrides the prediction with an archive-end word or
	// with nothing.
	task automatic send_word(input logic [7:0] b, input logic f, input bit use_typed,
			input bit t_has);
		bit        has;
		deframed_t w;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		first_byte <= f;
		do @(posedge clk); while (in_stall !== 1'b0);
		words_total++;
		if (!(p_state == ST_STOPPED && !f))
			words_fed++;
		deframe_byte(b, f, has, w);
		if (use_typed) begin
			has = t_has;
			w = {8'h00, KIND_END, 1'b0};
		end
		if (has)
			queue_word(w);
	endtask

	function automatic logic [7:0] pick_name_char();
		logic [7:0] v;
		case ($urandom_range(0, 9))
			0: v = 8'h40;
			1: v = 8'h41;
			2: v = 8'h5A;
			3: v = 8'h5B;
			4: v = 8'h61;
			5: v = 8'h7A;
			default: v = 8'($urandom_range(0, 255));
		endcase
		return v;
	endfunction

	// Sends one local entry: header, name, extra field and stored content.
	// cut > 0 truncates it; bad_sig >= 0 spoils that signature byte.
	task automatic send_entry(input int name_len, input int extra_len,
			input logic [31:0] packed_sz, input logic [31:0] plain_sz,
			input int cut, input int bad_sig);
		longint     total;
		logic [7:0] b;
		logic       f;
		total = longint'(30 + name_len + extra_len);
		if (packed_sz == plain_sz)
			total = total + longint'(packed_sz);
		else
			total = longint'(30 + $urandom_range(0, 2));
		if (bad_sig >= 0)
			total = longint'(bad_sig + 1 + $urandom_range(0, 3));
		if (cut > 0 && cut < total)
			total = longint'(cut);
		if (!quiet_tail && (idle_pct != 0 || $urandom_range(0, 3) != 0)) begin
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 15;
				default: idle_pct = 40;
			endcase
		end
		entries_sent++;
		for (int i = 0; i < total; i++) begin
			if (i < 4) begin
				b = ZIP_SIG[8 * i +: 8];
				if (i == bad_sig)
					b = b ^ 8'($urandom_range(1, 255));
			end else if (i < 18)
				b = 8'($urandom_range(0, 255));
			else if (i < 22)
				b = packed_sz[8 * (i - 18) +: 8];
			else if (i < 26)
				b = plain_sz[8 * (i - 22) +: 8];
			else if (i < 28)
				b = 8'(name_len >> (8 * (i - 26)));
			else if (i < 30)
				b = 8'(extra_len >> (8 * (i - 28)));
			else if (i < 30 + name_len)
				b = pick_name_char();
			else
				b = 8'($urandom_range(0, 255));
			// A new archive must start whenever the parser is not at a clean boundary.
			f = (i == 0) && (p_state != ST_HEADER || p_hdr_idx != 5'd0 ||
				$urandom_range(0, 3) == 0);
			send_word(b, f, 1'b0, 1'b0);
		end
	endtask

	function automatic logic [31:0] small_size();
		return ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 8));
	endfunction

	// Receiver: random stall bursts, plus one long hold on request.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				hold_long = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : rx_check
		deframed_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word byte=%h kind=%0d last=%b",
					out_byte, kind, last_of_entry));
			end else begin
				want = pending_words.pop_front();
				kind_count[want.kind]++;
				if (out_byte !== want.data)
					report_mismatch($sformatf("out_byte %h, expected %h (kind %0d)",
						out_byte, want.data, want.kind));
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
				if (last_of_entry !== want.last)
					report_mismatch($sformatf("last_of_entry %b, expected %b (kind %0d)",
						last_of_entry, want.last, want.kind));
			end
		end
	end

	initial begin
		int r;
		int goal;
		int base;
		bit hold_done;
		bit drain_done;
		hold_done = 1'b0;
		drain_done = 1'b0;
		in_valid <= 1'b0;
		in_byte <= 8'h00;
		first_byte <= 1'b0;
		arst_n <= 1'b0;
		p_state = ST_HEADER;
		p_hdr_idx = 5'd0;
		p_packed = 32'd0;
		p_plain = 32'd0;
		p_left = 32'd0;
		p_name_len = 16'd0;
		p_extra_len = 16'd0;

		// Signature checks byte by byte, the stopped state, and restarts.
		add_row(8'h00, 1'b0, 1'b1, 1'b1);
		add_row(8'hFF, 1'b0, 1'b1, 1'b0);
		add_row(8'h50, 1'b1, 1'b1, 1'b0);
		add_row(8'h4B, 1'b0, 1'b1, 1'b0);
		add_row(8'h03, 1'b0, 1'b1, 1'b0);
		add_row(8'h05, 1'b0, 1'b1, 1'b1);
		add_row(8'h50, 1'b0, 1'b1, 1'b0);
		add_row(8'hAF, 1'b1, 1'b1, 1'b1);
		add_row(8'h50, 1'b1, 1'b1, 1'b0);
		add_row(8'h4A, 1'b0, 1'b1, 1'b1);
		add_row(8'h50, 1'b1, 1'b1, 1'b0);
		add_row(8'h4B, 1'b0, 1'b1, 1'b0);
		add_row(8'h02, 1'b0, 1'b1, 1'b1);
		add_row(8'h50, 1'b1, 1'b1, 1'b0);
		add_row(8'h4B, 1'b0, 1'b1, 1'b0);
		add_row(8'h03, 1'b0, 1'b1, 1'b0);
		add_row(8'h04, 1'b0, 1'b1, 1'b0);
		add_row(8'hFF, 1'b0, 1'b0, 1'b0);
		add_row(8'h00, 1'b0, 1'b0, 1'b0);
		add_row(8'h50, 1'b1, 1'b0, 1'b0);
		add_row(8'h4B, 1'b0, 1'b0, 1'b0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].data, dir_rows[i].first, dir_rows[i].typed,
				dir_rows[i].t_has);

		// Entry-level cases: empty entries ending in header, name or extra,
		// normal content, size mismatches, huge entries cut short, and a bad signature.
		send_entry(0, 0, 32'd0, 32'd0, 0, -1);
		send_entry(3, 0, 32'd0, 32'd0, 0, -1);
		send_entry(0, 2, 32'd0, 32'd0, 0, -1);
		send_entry(2, 1, 32'd3, 32'd3, 0, -1);
		send_entry(1, 0, 32'h1234_5678, 32'h1234_5679, 0, -1);
		send_entry(1, 0, 32'h0100_0000, 32'h0000_0000, 0, -1);
		send_entry(65535, 65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40, -1);
		send_entry(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 37, -1);
		send_entry(1, 1, 32'd1, 32'd1, 0, -1);
		send_entry(0, 0, 32'd0, 32'd0, 0, 2);

		base = words_fed;
		goal = words_fed + RANDOM_WORDS;
		while (words_fed < goal) begin
			// Back-pressure: one long receiver hold, one drain of the sender.
			if (!hold_done && words_fed > base + 150) begin
				hold_done = 1'b1;
				hold_long = 1'b1;
			end
			if (!drain_done && words_fed > base + 250 && pending_words.size() != 0) begin
				drain_done = 1'b1;
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_words.size() != 0);
			end
			r = $urandom_range(0, 99);
			if (r < 8) begin
				repeat ($urandom_range(1, 6))
					send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
						1'b0, 1'b0);
			end else if (r < 14) begin
				send_entry(1, 0, 32'd1, 32'd1, 0, $urandom_range(0, 3));
			end else if (r < 22) begin
				send_entry($urandom_range(0, 3), $urandom_range(0, 2),
					$urandom, $urandom, 0, -1);
			end else if (r < 27) begin
				send_entry($urandom_range(0, 6), $urandom_range(0, 3), small_size() | 32'd1,
					32'd0, 0, -1);
			end else if (r < 32) begin
				send_entry($urandom_range(0, 6), $urandom_range(0, 3), 32'd8, 32'd8,
					$urandom_range(1, 42), -1);
			end else if (r < 35) begin
				r = $urandom;
				send_entry($urandom_range(0, 65535), $urandom_range(0, 65535), r, r,
					$urandom_range(30, 45), -1);
			end else begin
				r = small_size();
				send_entry($urandom_range(0, 6) * ($urandom_range(0, 3) != 0),
					$urandom_range(0, 3) * $urandom_range(0, 1), r, r, 0, -1);
			end
			if (words_fed > goal - 100) begin
				quiet_tail = 1'b1;
				idle_pct = 0;
			end
		end
		idle_pct = 0;
		in_valid <= 1'b0;

		for (int i = 0; i < 5000 && pending_words.size() != 0; i++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (pending_words.size() != 0)
			report_mismatch($sformatf("%0d expected words never came out",
				pending_words.size()));

		$display("Fed %0d parsed bytes (%0d in all) across %0d entries and noise.",
			words_fed, words_total, entries_sent);
		$display("Checked %0d name, %0d content, %0d empty-end, %0d archive-end, %0d reject.",
			kind_count[KIND_NAME], kind_count[KIND_DATA], kind_count[KIND_EMPTY],
			kind_count[KIND_END], kind_count[KIND_REJECT]);
		if (error_count == 0)
			$display("stored_zip_entry_deframer_tb: PASS");
		else
			$display("stored_zip_entry_deframer_tb: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("stored_zip_entry_deframer_tb: FAIL");
		$finish;
	end

endmodule

>>> files.f
sv/szd_pkg.sv
sv/szd_in_stage.sv
sv/szd_parse.sv
sv/szd_out_stage.sv
sv/stored_zip_entry_deframer.sv
sv/szd_checker.sv
tb/stored_zip_entry_deframer_tb.sv
